FILE: rtl/core/qcl_pkg.sv
// ----------------------------------------------------------------------------
// qcl_pkg
// Types, byte codes and the keyword table of the command-line parser.
// ----------------------------------------------------------------------------
package qcl_pkg;

	localparam int KEYWORD_MAX = 8;
	localparam int TOKEN_LIMIT = 255;
	localparam int KW_COUNT    = 19;
	localparam int KW_IDX_W    = $clog2(KEYWORD_MAX);
	localparam int KW_LEN_W    = $clog2(KEYWORD_MAX + 2);
	localparam int CMD_W       = 5;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_Z  = 8'h7A;
	localparam logic [7:0] CASE_GAP  = 8'h20;

	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_END     = 2'd1,
		KIND_VERDICT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_OPEN_ESCAPE = 3'd1,
		ST_OPEN_QUOTE  = 3'd2,
		ST_EMPTY       = 3'd3,
		ST_UNKNOWN     = 3'd4,
		ST_BAD_ARGS    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		NEED_EXACT      = 2'd0,
		NEED_ONE_PLUS   = 2'd1,
		NEED_EVEN_PAIRS = 2'd2
	} need_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data_byte;
		logic [7:0]       token_index;
		logic             last_of_run;
		status_t          status;
		logic [CMD_W-1:0] command;
		logic [7:0]       arg_total;
		logic             mutating;
	} res_t;

	localparam logic [8*KEYWORD_MAX-1:0] KW_TEXT [KW_COUNT+1] = '{
		64'h0, "SET", "GET", "DEL", "EXISTS", "EXPIRE", "EXPIREAT", "TTL",
		"PERSIST", "KEYS", "FLUSH", "PING", "INFO", "MSET", "MGET", "INCR",
		"DECR", "APPEND", "STRLEN", "SAVE"
	};

	localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT+1] = '{
		4'd0, 4'd3, 4'd3, 4'd3, 4'd6, 4'd6, 4'd8, 4'd3, 4'd7, 4'd4, 4'd5,
		4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd6, 4'd6, 4'd4
	};

	localparam need_t KW_NEED [KW_COUNT+1] = '{
		NEED_EXACT, NEED_EXACT, NEED_EXACT, NEED_EXACT, NEED_EXACT, NEED_EXACT,
		NEED_EXACT, NEED_EXACT, NEED_EXACT, NEED_EXACT, NEED_EXACT, NEED_EXACT,
		NEED_EXACT, NEED_EVEN_PAIRS, NEED_ONE_PLUS, NEED_EXACT, NEED_EXACT,
		NEED_EXACT, NEED_EXACT, NEED_EXACT
	};

	localparam logic [1:0] KW_ARGS [KW_COUNT+1] = '{
		2'd0, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0,
		2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd0
	};

	localparam logic KW_MUT [KW_COUNT+1] = '{
		1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1
	};

	function automatic logic [CMD_W-1:0] kw_match(
		input logic [KEYWORD_MAX-1:0][7:0] word,
		input logic [KW_LEN_W-1:0]         len
	);
		logic [CMD_W-1:0] hit;
		logic             same;
		int               pos;
		hit = '0;
		for (int k = 1; k <= KW_COUNT; k++) begin
			same = (KW_LEN[k] == len);
			for (int i = 0; i < KEYWORD_MAX; i++) begin
				if (i < int'(KW_LEN[k])) begin
					pos = 8 * (int'(KW_LEN[k]) - 1 - i);
					if (word[i] != KW_TEXT[k][pos +: 8])
						same = 1'b0;
				end
			end
			if (same && hit == '0)
				hit = CMD_W'(k);
		end
		return hit;
	endfunction

endpackage

FILE: rtl/core/qcl_in_if.sv
// ----------------------------------------------------------------------------
// qcl_in_if
// Line byte channel: at most one command-line byte per request.
// ----------------------------------------------------------------------------
interface qcl_in_if import qcl_pkg::*; ;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       char_valid;
	logic       line_end;

	modport source(output valid, ch, char_valid, line_end, input ready);
	modport sink(input valid, ch, char_valid, line_end, output ready);
endinterface

FILE: rtl/core/qcl_out_if.sv
// ----------------------------------------------------------------------------
// qcl_out_if
// Token channel: token bytes, token ends and line verdicts.
// ----------------------------------------------------------------------------
interface qcl_out_if import qcl_pkg::*; ;
	logic             valid;
	logic             ready;
	kind_t            kind;
	logic [7:0]       data_byte;
	logic [7:0]       token_index;
	logic             last_of_run;
	status_t          status;
	logic [CMD_W-1:0] command;
	logic [7:0]       arg_total;
	logic             mutating;

	modport source(output valid, kind, data_byte, token_index, last_of_run, status,
		command, arg_total, mutating, input ready);
	modport sink(input valid, kind, data_byte, token_index, last_of_run, status,
		command, arg_total, mutating, output ready);
endinterface

FILE: rtl/core/quoted_command_line_parser.sv
// ----------------------------------------------------------------------------
// quoted_command_line_parser
// Splits a command line into quoted tokens and classifies the command word.
// ----------------------------------------------------------------------------
// Timing: a request is registered in the input stage, then parsed into a result
//   group, registered once the previous group is taken, which offers the results.
// Throughput: one request per cycle while each gives at most one result and the
//   output is ready; more results hold the single port until all are taken.
// Reset: clears parser state, the input valid flag and the result count; the
//   keyword buffer is not reset; a match also needs the stored length to agree.
module quoted_command_line_parser import qcl_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	qcl_in_if.sink   line_in,
	qcl_out_if.source token_out
);

	logic       in_valid_s1;
	logic [7:0] ch_s1;
	logic       char_valid_s1;
	logic       line_end_s1;

	logic                          quoting_q;
	logic                          escape_q;
	logic                          open_q;
	logic [7:0]                    total_q;
	logic                          odd_q;
	logic [KEYWORD_MAX-1:0][7:0]   kw_buf_q;
	logic [KW_LEN_W-1:0]           kw_len_q;

	res_t       grp_s2 [3];
	logic [1:0] cnt_s2;
	logic [1:0] ptr_q;

	res_t                        res_c [3];
	logic [1:0]                  n_c;
	logic                        quoting_c;
	logic                        escape_c;
	logic                        open_c;
	logic [7:0]                  total_c;
	logic                        odd_c;
	logic [KEYWORD_MAX-1:0][7:0] kw_buf_c;
	logic [KW_LEN_W-1:0]         kw_len_c;

	logic pop;
	logic grp_last;
	logic grp_free;
	logic advance;

	assign pop       = token_out.valid && token_out.ready;
	assign grp_last  = (ptr_q == 2'(cnt_s2 - 2'd1));
	assign grp_free  = (cnt_s2 == 2'd0) || (pop && grp_last);
	assign advance   = in_valid_s1 && grp_free;
	assign line_in.ready = !in_valid_s1 || grp_free;

	always_comb begin : parse
		logic             take;
		logic [7:0]       b;
		logic             add;
		logic [CMD_W-1:0] cmd;
		logic             ok;
		logic [7:0]       args;
		res_t             r;
		take     = char_valid_s1 && !(line_end_s1 && ch_s1 == CH_CR);
		b        = ch_s1;
		add      = 1'b0;
		cmd      = '0;
		ok       = 1'b0;
		args     = '0;
		r        = '0;
		quoting_c = quoting_q;
		escape_c  = escape_q;
		open_c    = open_q;
		total_c   = total_q;
		odd_c     = odd_q;
		kw_buf_c  = kw_buf_q;
		kw_len_c  = kw_len_q;
		n_c       = 2'd0;
		for (int i = 0; i < 3; i++)
			res_c[i] = '0;

		if (take) begin
			if (escape_q) begin
				case (ch_s1)
					CH_LOW_N: b = CH_LF;
					CH_LOW_R: b = CH_CR;
					CH_LOW_T: b = CH_TAB;
					default:  b = ch_s1;
				endcase
				escape_c = 1'b0;
				add      = 1'b1;
			end else if (ch_s1 == CH_BSLASH && quoting_q) begin
				escape_c = 1'b1;
				open_c   = 1'b1;
			end else if (ch_s1 == CH_QUOTE) begin
				quoting_c = !quoting_q;
				open_c    = 1'b1;
			end else if (!quoting_q && (ch_s1 == CH_SPACE || ch_s1 inside {[CH_TAB:CH_CR]})) begin
				if (open_q) begin
					r             = '0;
					r.kind        = KIND_END;
					r.token_index = total_c;
					res_c[n_c]    = r;
					n_c           = n_c + 2'd1;
					if (total_c != 8'd0)
						odd_c = !odd_c;
					if (total_c < 8'(TOKEN_LIMIT))
						total_c = total_c + 8'd1;
					open_c = 1'b0;
				end
			end else begin
				add = 1'b1;
			end
		end

		if (add) begin
			open_c = 1'b1;
			if (total_c == 8'd0) begin
				if (kw_len_c < KW_LEN_W'(KEYWORD_MAX)) begin
					kw_buf_c[kw_len_c[KW_IDX_W-1:0]] =
						(b inside {[CH_LOW_A:CH_LOW_Z]}) ? 8'(b - CASE_GAP) : b;
					kw_len_c = kw_len_c + KW_LEN_W'(1);
				end else begin
					kw_len_c = KW_LEN_W'(KEYWORD_MAX + 1);
				end
			end
			r             = '0;
			r.kind        = KIND_BYTE;
			r.data_byte   = b;
			r.token_index = total_c;
			res_c[n_c]    = r;
			n_c           = n_c + 2'd1;
		end

		if (line_end_s1) begin
			r      = '0;
			r.kind = KIND_VERDICT;
			if (escape_c) begin
				r.status = ST_OPEN_ESCAPE;
			end else if (quoting_c) begin
				r.status = ST_OPEN_QUOTE;
			end else begin
				if (open_c) begin
					res_c[n_c]             = '0;
					res_c[n_c].kind        = KIND_END;
					res_c[n_c].token_index = total_c;
					n_c                    = n_c + 2'd1;
					if (total_c != 8'd0)
						odd_c = !odd_c;
					if (total_c < 8'(TOKEN_LIMIT))
						total_c = total_c + 8'd1;
				end
				if (total_c == 8'd0) begin
					r.status = ST_EMPTY;
				end else begin
					args = total_c - 8'd1;
					cmd  = (kw_len_c == '0) ? '0 : kw_match(kw_buf_c, kw_len_c);
					r.arg_total = args;
					if (cmd == '0) begin
						r.status = ST_UNKNOWN;
					end else begin
						case (KW_NEED[cmd])
							NEED_EXACT:      ok = (args == 8'(KW_ARGS[cmd]));
							NEED_ONE_PLUS:   ok = (total_c >= 8'd2);
							NEED_EVEN_PAIRS: ok = (total_c >= 8'd3) && !odd_c;
							default:         ok = 1'b0;
						endcase
						r.status   = ok ? ST_OK : ST_BAD_ARGS;
						r.command  = cmd;
						r.mutating = KW_MUT[cmd];
					end
				end
			end
			res_c[n_c] = r;
			n_c        = n_c + 2'd1;
			quoting_c = 1'b0;
			escape_c  = 1'b0;
			open_c    = 1'b0;
			total_c   = '0;
			odd_c     = 1'b0;
			kw_len_c  = '0;
		end

		if (n_c != 2'd0)
			res_c[2'(n_c - 2'd1)].last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (line_in.valid && line_in.ready) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (line_in.valid && line_in.ready) begin
			ch_s1         <= line_in.ch;
			char_valid_s1 <= line_in.char_valid;
			line_end_s1   <= line_in.line_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quoting_q <= 1'b0;
			escape_q  <= 1'b0;
			open_q    <= 1'b0;
			total_q   <= '0;
			odd_q     <= 1'b0;
			kw_len_q  <= '0;
		end else if (advance) begin
			quoting_q <= quoting_c;
			escape_q  <= escape_c;
			open_q    <= open_c;
			total_q   <= total_c;
			odd_q     <= odd_c;
			kw_len_q  <= kw_len_c;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			kw_buf_q <= kw_buf_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= 2'd0;
			ptr_q  <= 2'd0;
		end else if (advance) begin
			cnt_s2 <= n_c;
			ptr_q  <= 2'd0;
		end else if (pop) begin
			if (grp_last) begin
				cnt_s2 <= 2'd0;
				ptr_q  <= 2'd0;
			end else begin
				ptr_q <= ptr_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < 3; i++)
				grp_s2[i] <= res_c[i];
		end
	end

	assign token_out.valid       = (cnt_s2 != 2'd0);
	assign token_out.kind        = grp_s2[ptr_q].kind;
	assign token_out.data_byte   = grp_s2[ptr_q].data_byte;
	assign token_out.token_index = grp_s2[ptr_q].token_index;
	assign token_out.last_of_run = grp_s2[ptr_q].last_of_run;
	assign token_out.status      = grp_s2[ptr_q].status;
	assign token_out.command     = grp_s2[ptr_q].command;
	assign token_out.arg_total   = grp_s2[ptr_q].arg_total;
	assign token_out.mutating    = grp_s2[ptr_q].mutating;

	a_ptr_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_s2 != 2'd0 |-> ptr_q < cnt_s2)
		else $error("result pointer beyond group");

	a_escape_quoted: assert property (@(posedge clk) disable iff (!arst_n)
		escape_q |-> quoting_q)
		else $error("escape pending outside quotes");

	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && line_end_s1 |=> !quoting_q && !open_q && total_q == '0 && kw_len_q == '0)
		else $error("line state not cleared after verdict");

	a_kw_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kw_len_q <= KW_LEN_W'(KEYWORD_MAX + 1))
		else $error("keyword length out of range");

	a_group_last: assert property (@(posedge clk) disable iff (!arst_n)
		token_out.valid && grp_last |-> token_out.last_of_run)
		else $error("group ends without last marker");

endmodule

FILE: bench/tb_quoted_command_line_parser.sv
// ----------------------------------------------------------------------------
// tb_quoted_command_line_parser
// Feeds command lines byte by byte into the parser: special lines, then
// random well-formed and noisy lines. Token bytes, token ends and verdicts
// are predicted per request and compared in order on the token channel,
// with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_quoted_command_line_parser import qcl_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 5;
	localparam int IDLE_PCT     = 36;
	localparam int RANDOM_ITEMS = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int WATCHDOG_NS  = 4_000_000;
	localparam int CMD_COUNT    = 19;

	string cmd_name [CMD_COUNT] = '{
		"SET", "GET", "DEL", "EXISTS", "EXPIRE", "EXPIREAT", "TTL", "PERSIST",
		"KEYS", "FLUSH", "PING", "INFO", "MSET", "MGET", "INCR", "DECR",
		"APPEND", "STRLEN", "SAVE"
	};
	need_t cmd_need [CMD_COUNT] = '{
		NEED_EXACT, NEED_EXACT, NEED_EXACT, NEED_EXACT, NEED_EXACT, NEED_EXACT,
		NEED_EXACT, NEED_EXACT, NEED_EXACT, NEED_EXACT, NEED_EXACT, NEED_EXACT,
		NEED_EVEN_PAIRS, NEED_ONE_PLUS, NEED_EXACT, NEED_EXACT, NEED_EXACT,
		NEED_EXACT, NEED_EXACT
	};
	int cmd_args [CMD_COUNT] = '{2, 1, 1, 1, 2, 2, 1, 1, 0, 0, 0, 0, 0, 0, 1, 1, 2, 1, 0};
	bit cmd_mut [CMD_COUNT] = '{1, 0, 1, 0, 1, 1, 0, 1, 0, 1, 0, 0, 1, 0, 1, 1, 1, 0, 1};

	logic [7:0] gap_pool [6] = '{CH_SPACE, CH_TAB, CH_LF, 8'h0B, 8'h0C, CH_CR};
	logic [7:0] noise_pool [9] = '{
		CH_QUOTE, CH_BSLASH, CH_SPACE, CH_TAB, CH_CR, CH_LOW_N, CH_LOW_R, CH_LOW_T,
		CH_LOW_A
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	bit   steady = 1'b0;

	qcl_in_if  line_in();
	qcl_out_if token_out();

	quoted_command_line_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.line_in  (line_in),
		.token_out(token_out)
	);

	always #(CLK_HALF) clk = ~clk;

	// parser image
	bit          quoting   = 1'b0;
	bit          esc_open  = 1'b0;
	bit          tok_open  = 1'b0;
	bit          args_odd  = 1'b0;
	int unsigned tok_total = 0;
	int unsigned kw_len    = 0;
	logic [7:0]  kw_buf [KEYWORD_MAX];

	res_t        run_q [$];
	res_t        parsed_q [$];
	logic [7:0]  line_buf [$];
	int unsigned sent_items = 0;
	int unsigned result_no  = 0;
	int unsigned mismatches = 0;
	int unsigned rotation   = 0;

	function automatic void emit(kind_t k, logic [7:0] d, logic [7:0] idx, status_t st,
		logic [CMD_W-1:0] cmd, logic [7:0] args, logic mut);
		res_t r;
		r.kind        = k;
		r.data_byte   = d;
		r.token_index = idx;
		r.last_of_run = 1'b0;
		r.status      = st;
		r.command     = cmd;
		r.arg_total   = args;
		r.mutating    = mut;
		run_q = {run_q, r};
	endfunction

	function automatic logic [7:0] cur_index();
		return (tok_total > 255) ? 8'd255 : 8'(tok_total);
	endfunction

	function automatic void take_byte(logic [7:0] b);
		logic [7:0] up;
		tok_open = 1'b1;
		if (tok_total == 0) begin
			if (kw_len < KEYWORD_MAX) begin
				up = (b >= CH_LOW_A && b <= CH_LOW_Z) ? b - CASE_GAP : b;
				kw_buf[kw_len] = up;
				kw_len++;
			end else begin
				kw_len = KEYWORD_MAX + 1;
			end
		end
		emit(KIND_BYTE, b, cur_index(), ST_OK, '0, '0, 1'b0);
	endfunction

	function automatic void end_token();
		emit(KIND_END, '0, cur_index(), ST_OK, '0, '0, 1'b0);
		if (tok_total > 0)
			args_odd = !args_odd;
		if (tok_total < TOKEN_LIMIT)
			tok_total++;
		tok_open = 1'b0;
	endfunction

	function automatic int lookup_command();
		int hit;
		bit same;
		hit = 0;
		if (kw_len == 0 || kw_len > KEYWORD_MAX)
			return 0;
		for (int k = 0; k < CMD_COUNT; k++) begin
			if (hit == 0 && cmd_name[k].len() == kw_len) begin
				same = 1'b1;
				for (int i = 0; i < kw_len; i++)
					if (kw_buf[i] != cmd_name[k][i])
						same = 1'b0;
				if (same)
					hit = k + 1;
			end
		end
		return hit;
	endfunction

	function automatic void close_line();
		int          cmd;
		int unsigned args;
		bit          ok;
		if (esc_open) begin
			emit(KIND_VERDICT, '0, '0, ST_OPEN_ESCAPE, '0, '0, 1'b0);
		end else if (quoting) begin
			emit(KIND_VERDICT, '0, '0, ST_OPEN_QUOTE, '0, '0, 1'b0);
		end else begin
			if (tok_open)
				end_token();
			if (tok_total == 0) begin
				emit(KIND_VERDICT, '0, '0, ST_EMPTY, '0, '0, 1'b0);
			end else begin
				args = tok_total - 1;
				if (args > 255)
					args = 255;
				cmd = lookup_command();
				if (cmd == 0) begin
					emit(KIND_VERDICT, '0, '0, ST_UNKNOWN, '0, args[7:0], 1'b0);
				end else begin
					case (cmd_need[cmd-1])
						NEED_EXACT:    ok = (tok_total - 1) == cmd_args[cmd-1];
						NEED_ONE_PLUS: ok = tok_total >= 2;
						default:       ok = tok_total >= 3 && !args_odd;
					endcase
					emit(KIND_VERDICT, '0, '0, ok ? ST_OK : ST_BAD_ARGS, CMD_W'(cmd),
						args[7:0], cmd_mut[cmd-1]);
				end
			end
		end
		quoting   = 1'b0;
		esc_open  = 1'b0;
		tok_open  = 1'b0;
		tok_total = 0;
		args_odd  = 1'b0;
		kw_len    = 0;
	endfunction

	function automatic void parse_request(logic [7:0] c, logic cv, logic le);
		logic [7:0] b;
		run_q.delete();
		if (cv && !(le && c == CH_CR)) begin
			if (esc_open) begin
				b = (c == CH_LOW_N) ? CH_LF : (c == CH_LOW_R) ? CH_CR :
					(c == CH_LOW_T) ? CH_TAB : c;
				esc_open = 1'b0;
				take_byte(b);
			end else if (c == CH_BSLASH && quoting) begin
				esc_open = 1'b1;
				tok_open = 1'b1;
			end else if (c == CH_QUOTE) begin
				quoting  = !quoting;
				tok_open = 1'b1;
			end else if (!quoting && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
				if (tok_open)
					end_token();
			end else begin
				take_byte(c);
			end
		end
		if (le)
			close_line();
		if (run_q.size() > 0)
			run_q[run_q.size() - 1].last_of_run = 1'b1;
		parsed_q = {parsed_q, run_q};
	endfunction

	task automatic report(input string msg);
		$display("ERROR %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_result();
		res_t want;
		result_no++;
		if (parsed_q.size() == 0) begin
			report($sformatf("result %0d kind %0d arrived with nothing pending",
				result_no, token_out.kind));
		end else begin
			want = parsed_q.pop_front();
			if (token_out.kind !== want.kind)
				report($sformatf("result %0d kind: want %0d got %0d",
					result_no, want.kind, token_out.kind));
			if (token_out.data_byte !== want.data_byte)
				report($sformatf("result %0d data_byte: want %0h got %0h",
					result_no, want.data_byte, token_out.data_byte));
			if (token_out.token_index !== want.token_index)
				report($sformatf("result %0d token_index: want %0d got %0d",
					result_no, want.token_index, token_out.token_index));
			if (token_out.last_of_run !== want.last_of_run)
				report($sformatf("result %0d last_of_run: want %0d got %0d",
					result_no, want.last_of_run, token_out.last_of_run));
			if (token_out.status !== want.status)
				report($sformatf("result %0d status: want %0d got %0d",
					result_no, want.status, token_out.status));
			if (token_out.command !== want.command)
				report($sformatf("result %0d command: want %0d got %0d",
					result_no, want.command, token_out.command));
			if (token_out.arg_total !== want.arg_total)
				report($sformatf("result %0d arg_total: want %0d got %0d",
					result_no, want.arg_total, token_out.arg_total));
			if (token_out.mutating !== want.mutating)
				report($sformatf("result %0d mutating: want %0d got %0d",
					result_no, want.mutating, token_out.mutating));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && token_out.valid && token_out.ready)
			check_result();
	end

	initial begin
		token_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			token_out.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic send_req(input logic [7:0] c, input logic cv, input logic le);
		int gap;
		gap = 0;
		while (!steady && $urandom_range(99) < IDLE_PCT)
			gap++;
		if (gap > 0) begin
			line_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		line_in.valid      <= 1'b1;
		line_in.ch         <= c;
		line_in.char_valid <= cv;
		line_in.line_end   <= le;
		do
			@(posedge clk);
		while (line_in.ready !== 1'b1);
		parse_request(c, cv, le);
		sent_items++;
	endtask

	function automatic void put_byte(logic [7:0] b);
		line_buf = {line_buf, b};
	endfunction

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	task automatic send_line();
		if (line_buf.size() == 0) begin
			send_req(8'($urandom_range(255)), 1'b0, 1'b1);
		end else begin
			for (int i = 0; i < line_buf.size(); i++)
				send_req(line_buf[i], 1'b1, i == line_buf.size() - 1);
		end
		line_buf.delete();
	endtask

	task automatic put_gap();
		repeat ($urandom_range(1, 2))
			put_byte(gap_pool[$urandom_range(5)]);
	endtask

	task automatic put_word(input int kw);
		logic [7:0] b;
		bit         quoted;
		quoted = ($urandom_range(4) == 0);
		if (quoted)
			put_byte(CH_QUOTE);
		if (kw == CMD_COUNT) begin
			repeat ($urandom_range(1, 10)) begin
				b = 8'($urandom_range(8'h41, 8'h5A));
				put_byte($urandom_range(1) ? b + CASE_GAP : b);
			end
		end else begin
			for (int i = 0; i < cmd_name[kw].len(); i++) begin
				b = cmd_name[kw][i];
				put_byte($urandom_range(1) ? b + CASE_GAP : b);
			end
		end
		if (quoted)
			put_byte(CH_QUOTE);
	endtask

	task automatic put_arg();
		int         style;
		logic [7:0] b;
		style = $urandom_range(3);
		if (style != 1) begin
			repeat ($urandom_range(1, 4)) begin
				b = 8'($urandom_range(8'h21, 8'hFF));
				if (b == CH_QUOTE || b == 8'h7F)
					b = CH_LOW_A;
				put_byte(b);
			end
		end
		if (style >= 1) begin
			put_byte(CH_QUOTE);
			repeat ($urandom_range(0, 4)) begin
				case ($urandom_range(4))
					0: begin
						b = 8'($urandom_range(8'h20, 8'h7E));
						case ($urandom_range(3))
							0: b = CH_LOW_N;
							1: b = CH_LOW_R;
							2: b = CH_LOW_T;
							default: ;
						endcase
						put_byte(CH_BSLASH);
						put_byte(b);
					end
					1: put_byte(gap_pool[$urandom_range(1)]);
					default: begin
						b = 8'($urandom_range(8'h20, 8'h7E));
						if (b == CH_QUOTE || b == CH_BSLASH)
							b = CH_LOW_T;
						put_byte(b);
					end
				endcase
			end
			put_byte(CH_QUOTE);
		end
	endtask

	task automatic send_command_line();
		int kw;
		int nargs;
		kw = rotation % (CMD_COUNT + 1);
		rotation++;
		if ($urandom_range(3) == 0)
			put_gap();
		put_word(kw);
		if (kw == CMD_COUNT) begin
			nargs = $urandom_range(0, 3);
		end else begin
			case (cmd_need[kw])
				NEED_EXACT:
					nargs = ($urandom_range(3) != 0) ? cmd_args[kw] : $urandom_range(0, 3);
				NEED_ONE_PLUS:
					nargs = $urandom_range(0, 4);
				default:
					nargs = ($urandom_range(3) != 0) ? 2 * $urandom_range(1, 2)
						: $urandom_range(0, 5);
			endcase
		end
		repeat (nargs) begin
			put_gap();
			put_arg();
		end
		if ($urandom_range(3) == 0)
			put_gap();
		if ($urandom_range(3) == 0)
			put_byte(CH_CR);
		send_line();
	endtask

	task automatic send_noise_line();
		int         n;
		logic [7:0] c;
		n = $urandom_range(0, 12);
		for (int i = 0; i <= n; i++) begin
			c = ($urandom_range(4) < 2) ? 8'($urandom_range(255)) : noise_pool[$urandom_range(8)];
			if (i == n)
				send_req(c, $urandom_range(1) != 0, 1'b1);
			else
				send_req(c, $urandom_range(9) != 0, 1'b0);
		end
	endtask

	task automatic test_special_lines();
		send_line();
		send_req(CH_CR, 1'b1, 1'b1);
		put_text("\"\\n\\r\\t\\z\"");
		put_byte(CH_CR);
		send_line();
		put_text("a\"b");
		send_line();
		put_text("\"\\");
		put_byte(CH_CR);
		send_line();
		put_text("EXPIREATS");
		send_line();
		send_req(8'h00, 1'b1, 1'b0);
		send_req(8'hFF, 1'b1, 1'b0);
		send_req(8'hA5, 1'b0, 1'b0);
		send_req(8'h0B, 1'b1, 1'b0);
		send_req(8'h5A, 1'b0, 1'b1);
	endtask

	task automatic test_random_lines();
		int unsigned start;
		start = sent_items;
		while (sent_items - start < RANDOM_ITEMS) begin
			steady = (sent_items - start >= 110) && (sent_items - start < 210);
			if ($urandom_range(9) < 7)
				send_command_line();
			else
				send_noise_line();
		end
		steady = 1'b0;
	endtask

	task automatic finish_run();
		line_in.valid <= 1'b0;
		while (parsed_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("quoted_command_line_parser regression: pass");
		else
			$display("quoted_command_line_parser regression: fail");
		$finish;
	endtask

	initial begin
		line_in.valid      <= 1'b0;
		line_in.ch         <= '0;
		line_in.char_valid <= 1'b0;
		line_in.line_end   <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_lines();
		test_random_lines();
		finish_run();
	end

	initial begin
		#(WATCHDOG_NS);
		$display("quoted_command_line_parser regression: fail");
		$finish;
	end

endmodule
